### rtl/rbrd_pkg.sv
`timescale 1ns / 1ps
package rbrd_pkg;

   // Coordinate width of rows, edges and registers
   localparam int COORD_BITS = 12;
   // Signed working width: room for sums of two coordinates and for 3*min_size
   localparam int WIDE_BITS  = COORD_BITS + 3;
   // Configuration port geometry
   localparam int DATA_BITS  = 32;
   localparam int ADDR_BITS  = 4;
   localparam int IDX_BITS   = 2;

   typedef logic [COORD_BITS-1:0]       coord_type;
   typedef logic signed [WIDE_BITS-1:0] wide_type;

   typedef enum logic [IDX_BITS-1:0] {
      REG_SIDE_SELECT = 2'd0,
      REG_MIN_SIZE    = 2'd1,
      REG_MAIN_WIDTH  = 2'd2,
      REG_AXIS_X      = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic      side_select;
      coord_type min_size;
      coord_type main_width;
      coord_type axis_x;
   } cfg_type;

   typedef struct packed {
      logic      run_open;
      logic      gap_seen;
      coord_type gap_row;
      coord_type run_start_row;
      coord_type outer_edge;
   } state_type;

   typedef struct packed {
      coord_type row_y;
      coord_type edge_left;
      coord_type edge_right;
      logic      final_row;
   } row_type;

   typedef struct packed {
      coord_type box_center_x;
      coord_type box_center_y;
      coord_type box_width;
      coord_type box_height;
   } box_type;

   // Zero-extend a coordinate into the signed working width
   function automatic wide_type widen(input coord_type v);
      return wide_type'({{(WIDE_BITS-COORD_BITS){1'b0}}, v});
   endfunction

endpackage

### rtl/rbrd_row_eval.sv
`timescale 1ns / 1ps
module rbrd_row_eval (
   input  rbrd_pkg::cfg_type   cfg,
   input  rbrd_pkg::state_type state,
   input  rbrd_pkg::row_type   row,
   output rbrd_pkg::state_type state_next,
   output logic                emit,
   output rbrd_pkg::box_type   box
);
   import rbrd_pkg::*;

   wide_type w_left, w_right, w_axis, w_mw, w_thr, w_half_mw;
   wide_type span, reach, height, axis_off, dist_abs, width, height_min;
   logic     is_bulge, edge_better, close_en, height_ok, width_ok;
   coord_type row_edge, end_row;

   // Widen the operands once
   assign w_left    = widen(row.edge_left);
   assign w_right   = widen(row.edge_right);
   assign w_axis    = widen(cfg.axis_x);
   assign w_mw      = widen(cfg.main_width);
   assign w_thr     = widen(cfg.min_size);
   assign w_half_mw = w_mw >>> 1;

   // Classify the row: wide enough and reaching far enough on the chosen side
   assign span     = w_right - w_left;
   assign reach    = cfg.side_select ? (w_right - w_axis) : (w_axis - w_left);
   assign is_bulge = (span >= w_mw + w_thr) && (reach >= w_half_mw + w_thr);

   // Pick the edge of the chosen side and test whether it lies further out
   assign row_edge    = cfg.side_select ? row.edge_right : row.edge_left;
   assign edge_better = cfg.side_select ? (row_edge > state.outer_edge)
                                        : (row_edge < state.outer_edge);

   // Close on a second non-bulge row, or on a first one that ends the scan
   assign close_en = !is_bulge && state.run_open && (state.gap_seen || row.final_row);
   assign end_row  = state.gap_seen ? state.gap_row : row.row_y;

   // Box geometry of the run being closed
   assign height     = widen(end_row) - widen(state.run_start_row);
   assign height_min = ((w_thr <<< 1) + w_thr) >>> 1;
   assign height_ok  = height >= height_min;
   assign axis_off   = w_axis - widen(state.outer_edge);
   assign dist_abs   = axis_off[WIDE_BITS-1] ? -axis_off : axis_off;
   assign width      = dist_abs - w_half_mw;
   assign width_ok   = width >= w_thr;

   assign emit = close_en && height_ok && width_ok;

   always_comb begin
      wide_type cx;
      wide_type cy;
      cx = cfg.side_select ? (widen(state.outer_edge) - (width >>> 1))
                           : (widen(state.outer_edge) + (width >>> 1));
      cy = widen(state.run_start_row) + (height >>> 1);
      box.box_center_x = cx[COORD_BITS-1:0];
      box.box_center_y = cy[COORD_BITS-1:0];
      box.box_width    = width[COORD_BITS-1:0];
      box.box_height   = height[COORD_BITS-1:0];
   end

   // Advance the run tracker
   always_comb begin
      state_next = state;
      if (is_bulge) begin
         if (!state.run_open) begin
            state_next.run_open      = 1'b1;
            state_next.run_start_row = row.row_y;
            state_next.outer_edge    = row_edge;
         end else if (edge_better) begin
            state_next.outer_edge = row_edge;
         end
         state_next.gap_seen = 1'b0;
      end else if (state.run_open) begin
         if (close_en) begin
            state_next.run_open = 1'b0;
            state_next.gap_seen = 1'b0;
         end else begin
            state_next.gap_seen = 1'b1;
            state_next.gap_row  = row.row_y;
         end
      end
      if (row.final_row) begin
         state_next.run_open = 1'b0;
         state_next.gap_seen = 1'b0;
      end
   end

endmodule

### rtl/row_bulge_run_detector_unit.sv
`timescale 1ns / 1ps
// Flow: a row taken into the input register is evaluated there; its box (if any)
// is loaded into the result register and shown on the rsp_ ports.
// Throughput: one row per cycle unless a stalled result holds it; the run tracker
// state feeds back via a single evaluation stage between input and result registers.
// Reset: synchronous, active high; clears configuration, run tracker and valid flags.
module row_bulge_run_detector_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rbrd_pkg::COORD_BITS-1:0]     req_row_y,
   input  logic [rbrd_pkg::COORD_BITS-1:0]     req_edge_left,
   input  logic [rbrd_pkg::COORD_BITS-1:0]     req_edge_right,
   input  logic                                req_final_row,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rbrd_pkg::COORD_BITS-1:0]     rsp_box_center_x,
   output logic [rbrd_pkg::COORD_BITS-1:0]     rsp_box_center_y,
   output logic [rbrd_pkg::COORD_BITS-1:0]     rsp_box_width,
   output logic [rbrd_pkg::COORD_BITS-1:0]     rsp_box_height,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rbrd_pkg::ADDR_BITS-1:0]      paddr,
   input  logic [rbrd_pkg::DATA_BITS-1:0]      pwdata,
   output logic [rbrd_pkg::DATA_BITS-1:0]      prdata,
   output logic                                pready
);
   import rbrd_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   state_type   state_ff, state_next;
   row_type     s1_row_ff;
   logic        s1_valid_ff, s1_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   box_type     box_ff, box_calc;
   logic        emit;
   logic        req_accept, out_free, advance, csr_write;
   reg_idx_type csr_idx;

   // Configuration port
   assign pready    = 1'b1;
   assign csr_idx   = reg_idx_type'(paddr[ADDR_BITS-1:ADDR_BITS-IDX_BITS]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_idx)
            REG_SIDE_SELECT: cfg_in.side_select = pwdata[0];
            REG_MIN_SIZE:    cfg_in.min_size    = pwdata[COORD_BITS-1:0];
            REG_MAIN_WIDTH:  cfg_in.main_width  = pwdata[COORD_BITS-1:0];
            REG_AXIS_X:      cfg_in.axis_x      = pwdata[COORD_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SIDE_SELECT: prdata = {{(DATA_BITS-1){1'b0}}, cfg_ff.side_select};
         REG_MIN_SIZE:    prdata = {{(DATA_BITS-COORD_BITS){1'b0}}, cfg_ff.min_size};
         REG_MAIN_WIDTH:  prdata = {{(DATA_BITS-COORD_BITS){1'b0}}, cfg_ff.main_width};
         REG_AXIS_X:      prdata = {{(DATA_BITS-COORD_BITS){1'b0}}, cfg_ff.axis_x};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Handshake: the input register drains whenever the result register can load
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign advance     = s1_valid_ff && out_free;
   assign req_stall   = s1_valid_ff && !out_free;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !advance);

   // Capture the row on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_row_ff.row_y      <= req_row_y;
         s1_row_ff.edge_left  <= req_edge_left;
         s1_row_ff.edge_right <= req_edge_right;
         s1_row_ff.final_row  <= req_final_row;
      end
   end

   // Evaluate the held row against the run tracker
   rbrd_row_eval u_eval (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .row        (s1_row_ff),
      .state_next (state_next),
      .emit       (emit),
      .box        (box_calc)
   );

   // Hold the tracker unless a row advances
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_next;
      end
   end

   // Result register: load on an advance that emits a box, drop once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = advance && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         box_ff <= box_calc;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_box_center_x = box_ff.box_center_x;
   assign rsp_box_center_y = box_ff.box_center_y;
   assign rsp_box_width    = box_ff.box_width;
   assign rsp_box_height   = box_ff.box_height;

`ifndef SYNTHESIS
   // A new result only follows a row leaving the input register
   a_rsp_from_row: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without an evaluated row");

   // A pending gap always belongs to an open run
   a_gap_in_run: assert property (@(posedge clock) disable iff (reset)
      state_ff.gap_seen |-> state_ff.run_open)
      else $error("gap flagged with no open run");

   // The last row of a scan leaves the tracker idle
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_row_ff.final_row) |=> (!state_ff.run_open && !state_ff.gap_seen))
      else $error("run still open after final row");
`endif

endmodule

### test/rbrd_box_checker.sv
`timescale 1ns / 1ps
module rbrd_box_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [rbrd_pkg::COORD_BITS-1:0] req_row_y,
   input  logic [rbrd_pkg::COORD_BITS-1:0] req_edge_left,
   input  logic [rbrd_pkg::COORD_BITS-1:0] req_edge_right,
   input  logic                            req_final_row,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [rbrd_pkg::COORD_BITS-1:0] rsp_box_center_x,
   input  logic [rbrd_pkg::COORD_BITS-1:0] rsp_box_center_y,
   input  logic [rbrd_pkg::COORD_BITS-1:0] rsp_box_width,
   input  logic [rbrd_pkg::COORD_BITS-1:0] rsp_box_height,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic                            pready,
   input  logic [rbrd_pkg::ADDR_BITS-1:0]  paddr,
   input  logic [rbrd_pkg::DATA_BITS-1:0]  pwdata,
   output int                              fail_count,
   output int                              pending_count
);
   import rbrd_pkg::*;

   // Shadow copies of the configuration and the run tracker
   cfg_type   cfg;
   state_type trk;
   box_type   pending_boxes[$];

   // Decide whether a row reaches past the body far enough to count as a bulge
   function automatic bit is_bulge(input coord_type left, input coord_type right);
      int thr;
      int mw;
      int ax;
      int reach;
      thr   = int'(cfg.min_size);
      mw    = int'(cfg.main_width);
      ax    = int'(cfg.axis_x);
      reach = cfg.side_select ? int'(right) - ax : ax - int'(left);
      return (int'(right) - int'(left) >= mw + thr) && (reach >= mw / 2 + thr);
   endfunction

   // Close the open run at end_row; return 1 when the run is large enough for a box
   function automatic bit close_run_at(input coord_type end_row, output box_type box);
      int thr;
      int height;
      int bound;
      int axis_off;
      int width;
      int cx;
      int cy;
      thr      = int'(cfg.min_size);
      height   = int'(end_row) - int'(trk.run_start_row);
      bound    = int'(trk.outer_edge);
      axis_off = int'(cfg.axis_x) - bound;
      if (axis_off < 0) begin
         axis_off = -axis_off;
      end
      width        = axis_off - int'(cfg.main_width) / 2;
      trk.run_open = 1'b0;
      trk.gap_seen = 1'b0;
      box          = '0;
      if (height < (3 * thr) / 2 || width < thr) begin
         return 1'b0;
      end
      cx = cfg.side_select ? bound - width / 2 : bound + width / 2;
      cy = int'(trk.run_start_row) + height / 2;
      box.box_center_x = cx[COORD_BITS-1:0];
      box.box_center_y = cy[COORD_BITS-1:0];
      box.box_width    = width[COORD_BITS-1:0];
      box.box_height   = height[COORD_BITS-1:0];
      return 1'b1;
   endfunction

   // Advance the run tracker by one row; return 1 when the row closes a run with a box
   function automatic bit track_row(input row_type row, output box_type box);
      coord_type e;
      bit        found;
      found = 1'b0;
      box   = '0;
      if (is_bulge(row.edge_left, row.edge_right)) begin
         e = cfg.side_select ? row.edge_right : row.edge_left;
         if (!trk.run_open) begin
            trk.run_open      = 1'b1;
            trk.run_start_row = row.row_y;
            trk.outer_edge    = e;
         end else if (cfg.side_select ? (e > trk.outer_edge) : (e < trk.outer_edge)) begin
            trk.outer_edge = e;
         end
         trk.gap_seen = 1'b0;
      end else if (trk.run_open) begin
         if (trk.gap_seen) begin
            found = close_run_at(trk.gap_row, box);
         end else if (row.final_row) begin
            found = close_run_at(row.row_y, box);
         end else begin
            trk.gap_seen = 1'b1;
            trk.gap_row  = row.row_y;
         end
      end
      // A final row always starts a fresh scan
      if (row.final_row) begin
         trk.run_open = 1'b0;
         trk.gap_seen = 1'b0;
      end
      return found;
   endfunction

   task automatic check_field(input string name, input coord_type want, input coord_type got);
      if (want !== got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Watch both channels and the register port at each rising edge
   always @(posedge clock) begin : monitor
      row_type row;
      box_type box;
      box_type want;
      if (reset) begin
         cfg = '0;
         trk = '0;
         pending_boxes.delete();
      end else begin
         // Compare a result transfer with the oldest expected box
         if (rsp_valid && !rsp_stall) begin
            if (pending_boxes.size() == 0) begin
               $error("unexpected box transfer x=%0d y=%0d w=%0d h=%0d", rsp_box_center_x,
                      rsp_box_center_y, rsp_box_width, rsp_box_height);
               fail_count++;
            end else begin
               want = pending_boxes.pop_front();
               check_field("box_center_x", want.box_center_x, rsp_box_center_x);
               check_field("box_center_y", want.box_center_y, rsp_box_center_y);
               check_field("box_width", want.box_width, rsp_box_width);
               check_field("box_height", want.box_height, rsp_box_height);
            end
         end
         // Predict the box caused by a row transfer
         if (req_valid && !req_stall) begin
            row.row_y      = req_row_y;
            row.edge_left  = req_edge_left;
            row.edge_right = req_edge_right;
            row.final_row  = req_final_row;
            if (track_row(row, box)) begin
               pending_boxes.insert(pending_boxes.size(), box);
            end
         end
         // Track register writes
         if (psel && penable && pwrite && pready) begin
            unique case (reg_idx_type'(paddr[3:2]))
               REG_SIDE_SELECT: cfg.side_select = pwdata[0];
               REG_MIN_SIZE:    cfg.min_size    = pwdata[COORD_BITS-1:0];
               REG_MAIN_WIDTH:  cfg.main_width  = pwdata[COORD_BITS-1:0];
               REG_AXIS_X:      cfg.axis_x      = pwdata[COORD_BITS-1:0];
            endcase
         end
      end
      pending_count = pending_boxes.size();
   end

endmodule

### test/tb_row_bulge_run_detector_unit.sv
`timescale 1ns / 1ps
module tb_row_bulge_run_detector_unit;
   import rbrd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 80;
   localparam int HOLD_AT      = 350;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 6;

   typedef enum int {ROW_BODY, ROW_BULGE, ROW_NEAR} row_kind_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [COORD_BITS-1:0] req_row_y      = '0;
   logic [COORD_BITS-1:0] req_edge_left  = '0;
   logic [COORD_BITS-1:0] req_edge_right = '0;
   logic                  req_final_row  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [COORD_BITS-1:0] rsp_box_center_x;
   logic [COORD_BITS-1:0] rsp_box_center_y;
   logic [COORD_BITS-1:0] rsp_box_width;
   logic [COORD_BITS-1:0] rsp_box_height;
   logic                  psel           = 1'b0;
   logic                  penable        = 1'b0;
   logic                  pwrite         = 1'b0;
   logic [ADDR_BITS-1:0]  paddr          = '0;
   logic [DATA_BITS-1:0]  pwdata         = '0;
   logic [DATA_BITS-1:0]  prdata;
   logic                  pready;
   int                    fail_count;
   int                    pending_count;

   // Stimulus bookkeeping and the configuration currently loaded
   int items_sent = 0;
   int burst_left = 0;
   int cycles     = 0;
   bit cur_side;
   int cur_thr;
   int cur_mw;
   int cur_ax;

   row_bulge_run_detector_unit u_dut (.*);

   rbrd_box_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // End the run if it hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: stall on changing patterns, with one long hold-off mid-run
   initial begin : receiver
      stall_mode_type mode;
      int             left;
      bit             held;
      mode = STALL_NONE;
      left = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && items_sent >= HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               left = $urandom_range(20, 80);
            end
            left--;
            unique case (mode)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 4) < 3);
               STALL_TOGGLE: rsp_stall <= ~rsp_stall;
               default:      rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // One register write: setup phase, then access phase until pready
   task automatic write_reg(input reg_idx_type idx, input int unsigned value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= ($urandom & 32'hFFFF_F000) | value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
   endtask

   task automatic set_config(input bit side, input int thr, input int mw, input int ax);
      cur_side = side;
      cur_thr  = thr;
      cur_mw   = mw;
      cur_ax   = ax;
      write_reg(REG_SIDE_SELECT, 32'(side));
      write_reg(REG_MIN_SIZE, thr);
      write_reg(REG_MAIN_WIDTH, mw);
      write_reg(REG_AXIS_X, ax);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Offer one row in bursts separated by random gaps; return once it is transferred
   task automatic push_row(input coord_type y, input coord_type l, input coord_type r,
                           input bit f);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_row_y      <= y;
      req_edge_left  <= l;
      req_edge_right <= r;
      req_final_row  <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   // Drop valid and let the block drain before touching the registers
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > 4095) return 4095;
      return v;
   endfunction

   // Build a row of the given shape around the current body geometry
   task automatic emit_row(input row_kind_type kind, input int y, input bit f);
      int l;
      int r;
      int ext;
      if (kind == ROW_BODY) begin
         l = cur_ax - cur_mw / 4;
         r = cur_ax + cur_mw / 4;
      end else begin
         // A near miss reaches one pixel short of the bulge bound
         ext = (kind == ROW_NEAR) ? -1 : $urandom_range(0, 60);
         if (cur_side) begin
            r = cur_ax + cur_mw / 2 + cur_thr + ext;
            l = r - cur_mw - cur_thr - $urandom_range(0, 40);
         end else begin
            l = cur_ax - cur_mw / 2 - cur_thr - ext;
            r = l + cur_mw + cur_thr + $urandom_range(0, 40);
         end
      end
      l = clamp_coord(l);
      r = clamp_coord(r);
      push_row(y[COORD_BITS-1:0], l[COORD_BITS-1:0], r[COORD_BITS-1:0], f);
   endtask

   // One scan: body stretches alternating with bulge runs, last row flagged final
   task automatic send_scan(input int n_rows);
      int           y;
      int           k;
      int           seg;
      int           i;
      row_kind_type kind;
      y = $urandom_range(0, 300);
      k = 0;
      while (k < n_rows) begin
         seg = $urandom_range(1, 3);
         for (i = 0; i < seg && k < n_rows; i++) begin
            emit_row(ROW_BODY, y, k == n_rows - 1);
            k++;
            y = (y + (($urandom_range(0, 39) == 0) ? -$urandom_range(1, 5)
                                                    : $urandom_range(1, 2))) & 32'hFFF;
         end
         seg = (3 * cur_thr) / 2 + $urandom_range(0, 4);
         if (seg > 30) begin
            seg = 30;
         end
         for (i = 0; i < seg && k < n_rows; i++) begin
            kind = ROW_BULGE;
            if ($urandom_range(0, 7) == 0) begin
               kind = ROW_BODY;
            end else if ($urandom_range(0, 15) == 0) begin
               kind = ROW_NEAR;
            end
            emit_row(kind, y, k == n_rows - 1);
            k++;
            y = (y + (($urandom_range(0, 39) == 0) ? -$urandom_range(1, 5)
                                                    : $urandom_range(1, 2))) & 32'hFFF;
         end
      end
   endtask

   initial begin : stimulus
      int ph;
      int start;
      int n;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed rows: left side, threshold 4, body 100 wide around x 2000
      set_config(1'b0, 4, 100, 2000);
      push_row(12'd0, 12'd0, 12'd0, 1'b0);
      push_row(12'd1, 12'd4095, 12'd4095, 1'b0);
      // reversed edges
      push_row(12'd2, 12'd2040, 12'd1960, 1'b0);
      // widest row opens a run too short for a box
      push_row(12'd3, 12'd0, 12'd4095, 1'b0);
      push_row(12'd4, 12'd1960, 12'd2040, 1'b0);
      push_row(12'd5, 12'd1960, 12'd2040, 1'b0);
      // single gap bridged, then two body rows close the run
      push_row(12'd10, 12'd1920, 12'd2060, 1'b0);
      push_row(12'd12, 12'd1900, 12'd2060, 1'b0);
      push_row(12'd14, 12'd1960, 12'd2040, 1'b0);
      push_row(12'd16, 12'd1890, 12'd2060, 1'b0);
      push_row(12'd18, 12'd1960, 12'd2040, 1'b0);
      push_row(12'd20, 12'd1960, 12'd2040, 1'b0);
      // final row is the first body row: run closes there
      push_row(12'd30, 12'd1900, 12'd2060, 1'b0);
      push_row(12'd33, 12'd1900, 12'd2060, 1'b0);
      push_row(12'd36, 12'd1960, 12'd2040, 1'b1);
      // final row still a bulge: run dropped
      push_row(12'd40, 12'd1900, 12'd2060, 1'b0);
      push_row(12'd44, 12'd1900, 12'd2060, 1'b1);
      // rows going backwards: negative height
      push_row(12'd100, 12'd1900, 12'd2060, 1'b0);
      push_row(12'd102, 12'd1900, 12'd2060, 1'b0);
      push_row(12'd50, 12'd1960, 12'd2040, 1'b0);
      push_row(12'd52, 12'd1960, 12'd2040, 1'b0);
      // width exactly at the threshold
      push_row(12'd60, 12'd1946, 12'd2050, 1'b0);
      push_row(12'd64, 12'd1946, 12'd2050, 1'b0);
      push_row(12'd68, 12'd1960, 12'd2040, 1'b0);
      push_row(12'd70, 12'd1960, 12'd2040, 1'b1);
      wait_drained();

      // Random phases, each with its own configuration
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         unique case (ph)
            0:       set_config(1'b0, 0, 0, 0);
            1:       set_config(1'b1, 4095, 4095, 4095);
            2:       set_config(1'b0, 0, $urandom_range(20, 600), $urandom_range(800, 3200));
            default: set_config(ph[0], $urandom_range(1, 20), $urandom_range(20, 600),
                                $urandom_range(800, 3200));
         endcase
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
               send_scan($urandom_range(6, 40));
            end else begin
               n = $urandom_range(1, 4);
               repeat (n) begin
                  push_row(coord_type'($urandom_range(0, 4095)),
                           coord_type'($urandom_range(0, 4095)),
                           coord_type'($urandom_range(0, 4095)),
                           $urandom_range(0, 7) == 0);
               end
            end
         end
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
